/* design/im2c_pkg.sv */
package im2c_pkg;

    // Field widths
    localparam int LEN_W      = 20;
    localparam int CHAN_W     = 12;
    localparam int CNT8_W     = 8;
    localparam int PAD_W      = 10;
    localparam int WORD_W     = 32;
    localparam int INDEX_W    = 40;
    localparam int WSTART_W   = 30;
    localparam int OFFSET_W   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    // Float32 constants
    localparam logic [WORD_W-1:0] ABS_MASK  = 32'h7fff_ffff;
    localparam logic [WORD_W-1:0] INF_BITS  = 32'h7f80_0000;
    localparam logic [WORD_W-1:0] NEG_ZERO  = 32'h8000_0000;
    localparam logic [WORD_W-1:0] CANON_NAN = 32'h7fff_ffff;

    // Input item kinds
    localparam logic KIND_ADDR = 1'b0;
    localparam logic KIND_WORD = 1'b1;

    // Register map
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INPUT_LENGTH  = 3'd0,
        CFG_NUM_CHANNELS  = 3'd1,
        CFG_BATCH_COUNT   = 3'd2,
        CFG_TAP_COUNT     = 3'd3,
        CFG_OUTPUT_LENGTH = 3'd4,
        CFG_STEP_SIZE     = 3'd5,
        CFG_PAD_AMOUNT    = 3'd6,
        CFG_TAP_SPACING   = 3'd7
    } t_cfg_index;

    // Walk geometry
    typedef struct packed {
        logic [LEN_W-1:0]  input_length;
        logic [CHAN_W-1:0] num_channels;
        logic [CNT8_W-1:0] batch_count;
        logic [CNT8_W-1:0] tap_count;
        logic [LEN_W-1:0]  output_length;
        logic [CNT8_W-1:0] step_size;
        logic [PAD_W-1:0]  pad_amount;
        logic [CNT8_W-1:0] tap_spacing;
    } t_cfg;

    // Address of the current element
    typedef struct packed {
        logic [INDEX_W-1:0] source_index;
        logic               zero_fill;
        logic               final_element;
    } t_addr;

    // Map every NaN to one quiet NaN and negative zero to zero
    function automatic logic [WORD_W-1:0] normalize_word(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] res;
        if ((w & ABS_MASK) > INF_BITS) begin
            res = CANON_NAN;
        end else if (w == NEG_ZERO) begin
            res = '0;
        end else begin
            res = w;
        end
        return res;
    endfunction

endpackage

/* design/im2c_if.sv */
// Input item channel
interface im2c_in_if;
    logic                            valid;
    logic                            ready;
    logic                            kind;
    logic [im2c_pkg::WORD_W-1:0]     returned_word;

    modport source (output valid, output kind, output returned_word, input ready);
    modport sink   (input valid, input kind, input returned_word, output ready);
endinterface

// Result item channel
interface im2c_out_if;
    logic                            valid;
    logic                            ready;
    logic                            result_kind;
    logic [im2c_pkg::INDEX_W-1:0]    source_index;
    logic                            zero_fill;
    logic                            final_element;
    logic [im2c_pkg::WORD_W-1:0]     out_word;

    modport source (output valid, output result_kind, output source_index,
                    output zero_fill, output final_element, output out_word,
                    input ready);
    modport sink   (input valid, input result_kind, input source_index,
                    input zero_fill, input final_element, input out_word,
                    output ready);
endinterface

// Register write channel
interface im2c_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [im2c_pkg::CFG_IDX_W-1:0]    index;
    logic [im2c_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* design/im2c_walker.sv */
module im2c_walker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  im2c_pkg::t_cfg  i_cfg,
    input  logic            i_advance,
    output im2c_pkg::t_addr o_addr
);

    logic [im2c_pkg::CNT8_W-1:0]   r_tap_pos,     n_tap_pos;
    logic [im2c_pkg::CHAN_W-1:0]   r_channel_pos, n_channel_pos;
    logic [im2c_pkg::LEN_W-1:0]    r_out_pos,     n_out_pos;
    logic [im2c_pkg::CNT8_W-1:0]   r_batch_pos,   n_batch_pos;
    logic [im2c_pkg::WSTART_W-1:0] r_window_start, n_window_start;
    logic [im2c_pkg::OFFSET_W-1:0] r_tap_offset,  n_tap_offset;
    logic [im2c_pkg::INDEX_W-1:0]  r_row_base,    n_row_base;
    logic [im2c_pkg::INDEX_W-1:0]  r_batch_base,  n_batch_base;

    logic signed [im2c_pkg::WSTART_W:0] tap_time;
    logic [im2c_pkg::INDEX_W-1:0]       row_next;
    logic [im2c_pkg::WSTART_W-1:0]      window_reset;
    logic tap_wrap, ch_wrap, ow_wrap, b_wrap;

    // Tapped time, its bounds check and the last-element flag
    always_comb begin
        tap_time = $signed({r_window_start[im2c_pkg::WSTART_W-1], r_window_start})
                 + $signed({15'd0, r_tap_offset});
        o_addr.zero_fill = tap_time[im2c_pkg::WSTART_W]
            || (tap_time[im2c_pkg::WSTART_W-1:0]
                >= {{(im2c_pkg::WSTART_W-im2c_pkg::LEN_W){1'b0}}, i_cfg.input_length});
        o_addr.source_index = o_addr.zero_fill ? '0
            : r_row_base + {{(im2c_pkg::INDEX_W-im2c_pkg::WSTART_W){1'b0}},
                            tap_time[im2c_pkg::WSTART_W-1:0]};
        o_addr.final_element = tap_wrap && ch_wrap && ow_wrap && b_wrap;
    end

    // Counter wrap flags, a count of zero acts as one
    assign tap_wrap = ({1'b0, r_tap_pos} + 9'd1) >= {1'b0, i_cfg.tap_count};
    assign ch_wrap  = ({1'b0, r_channel_pos} + 13'd1) >= {1'b0, i_cfg.num_channels};
    assign ow_wrap  = ({1'b0, r_out_pos} + 21'd1) >= {1'b0, i_cfg.output_length};
    assign b_wrap   = ({1'b0, r_batch_pos} + 9'd1) >= {1'b0, i_cfg.batch_count};

    assign row_next = r_row_base
        + {{(im2c_pkg::INDEX_W-im2c_pkg::LEN_W){1'b0}}, i_cfg.input_length};
    assign window_reset = '0
        - {{(im2c_pkg::WSTART_W-im2c_pkg::PAD_W){1'b0}}, i_cfg.pad_amount};

    // Advance the nested counters on each address request
    always_comb begin
        n_tap_pos      = r_tap_pos;
        n_channel_pos  = r_channel_pos;
        n_out_pos      = r_out_pos;
        n_batch_pos    = r_batch_pos;
        n_window_start = r_window_start;
        n_tap_offset   = r_tap_offset;
        n_row_base     = r_row_base;
        n_batch_base   = r_batch_base;
        if (i_advance) begin
            if (!tap_wrap) begin
                n_tap_pos    = r_tap_pos + 8'd1;
                n_tap_offset = r_tap_offset
                    + {{(im2c_pkg::OFFSET_W-im2c_pkg::CNT8_W){1'b0}}, i_cfg.tap_spacing};
            end else if (!ch_wrap) begin
                n_tap_pos     = '0;
                n_tap_offset  = '0;
                n_channel_pos = r_channel_pos + 12'd1;
                n_row_base    = row_next;
            end else if (!ow_wrap) begin
                n_tap_pos      = '0;
                n_tap_offset   = '0;
                n_channel_pos  = '0;
                n_out_pos      = r_out_pos + 20'd1;
                n_window_start = r_window_start
                    + {{(im2c_pkg::WSTART_W-im2c_pkg::CNT8_W){1'b0}}, i_cfg.step_size};
                n_row_base     = r_batch_base;
            end else if (!b_wrap) begin
                n_tap_pos      = '0;
                n_tap_offset   = '0;
                n_channel_pos  = '0;
                n_out_pos      = '0;
                n_batch_pos    = r_batch_pos + 8'd1;
                n_window_start = window_reset;
                n_row_base     = row_next;
                n_batch_base   = row_next;
            end else begin
                n_tap_pos      = '0;
                n_tap_offset   = '0;
                n_channel_pos  = '0;
                n_out_pos      = '0;
                n_batch_pos    = '0;
                n_window_start = window_reset;
                n_row_base     = '0;
                n_batch_base   = '0;
            end
        end
    end

    // Walk state, padding is zero after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_pos      <= '0;
            r_channel_pos  <= '0;
            r_out_pos      <= '0;
            r_batch_pos    <= '0;
            r_window_start <= '0;
            r_tap_offset   <= '0;
            r_row_base     <= '0;
            r_batch_base   <= '0;
        end else begin
            r_tap_pos      <= n_tap_pos;
            r_channel_pos  <= n_channel_pos;
            r_out_pos      <= n_out_pos;
            r_batch_pos    <= n_batch_pos;
            r_window_start <= n_window_start;
            r_tap_offset   <= n_tap_offset;
            r_row_base     <= n_row_base;
            r_batch_base   <= n_batch_base;
        end
    end

endmodule

/* design/im2col1d_gather_address_generator_core.sv */
// 1-D im2col gather address generator.
// i_in carries items of two kinds. An address request (kind 0) returns the
// source word index of the next im2col element, walked tap fastest, then
// channel, output position and batch, with a zero-fill flag for taps in the
// padding and a final flag on the last element, after which the walk restarts.
// A returned word (kind 1) comes back normalized (NaN to 0x7fffffff, -0 to +0)
// and leaves the walk untouched.
// o_out gives one result beat per input beat, in order, in the cycle after
// the input beat is taken. Throughput is one beat per cycle unless the
// receiver stalls: the walk counters update by additions only, and the
// single output register takes a new beat whenever it is empty or being
// drained in the same cycle. When the receiver stalls, the output register
// holds its beat and i_in.ready drops until the beat is taken.
// i_cfg writes one geometry register per beat and is always ready; write it
// only while no beat is in flight.
// Reset restores the default geometry, restarts the walk and empties the
// output register.
module im2col1d_gather_address_generator_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    im2c_cfg_if.sink   i_cfg,
    im2c_in_if.sink    i_in,
    im2c_out_if.source o_out
);

    im2c_pkg::t_cfg  r_cfg;
    im2c_pkg::t_addr addr;
    logic            in_take;
    logic            advance;

    logic                           r_valid;
    logic                           r_kind;
    logic [im2c_pkg::INDEX_W-1:0]   r_source_index;
    logic                           r_zero_fill;
    logic                           r_final_element;
    logic [im2c_pkg::WORD_W-1:0]    r_out_word;

    // Configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.input_length  <= 20'd1;
            r_cfg.num_channels  <= 12'd1;
            r_cfg.batch_count   <= 8'd1;
            r_cfg.tap_count     <= 8'd3;
            r_cfg.output_length <= 20'd1;
            r_cfg.step_size     <= 8'd1;
            r_cfg.pad_amount    <= 10'd0;
            r_cfg.tap_spacing   <= 8'd1;
        end else if (i_cfg.valid) begin
            unique case (im2c_pkg::t_cfg_index'(i_cfg.index))
                im2c_pkg::CFG_INPUT_LENGTH:  r_cfg.input_length  <= i_cfg.data;
                im2c_pkg::CFG_NUM_CHANNELS:  r_cfg.num_channels  <= i_cfg.data[11:0];
                im2c_pkg::CFG_BATCH_COUNT:   r_cfg.batch_count   <= i_cfg.data[7:0];
                im2c_pkg::CFG_TAP_COUNT:     r_cfg.tap_count     <= i_cfg.data[7:0];
                im2c_pkg::CFG_OUTPUT_LENGTH: r_cfg.output_length <= i_cfg.data;
                im2c_pkg::CFG_STEP_SIZE:     r_cfg.step_size     <= i_cfg.data[7:0];
                im2c_pkg::CFG_PAD_AMOUNT:    r_cfg.pad_amount    <= i_cfg.data[9:0];
                im2c_pkg::CFG_TAP_SPACING:   r_cfg.tap_spacing   <= i_cfg.data[7:0];
            endcase
        end
    end

    // Take a beat when the output register is empty or draining
    assign i_in.ready = !r_valid || o_out.ready;
    assign in_take    = i_in.valid && i_in.ready;
    assign advance    = in_take && (i_in.kind == im2c_pkg::KIND_ADDR);

    im2c_walker u_walker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_advance (advance),
        .o_addr    (addr)
    );

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= in_take || (r_valid && !o_out.ready);
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_kind <= i_in.kind;
            if (i_in.kind == im2c_pkg::KIND_WORD) begin
                r_source_index  <= '0;
                r_zero_fill     <= 1'b0;
                r_final_element <= 1'b0;
                r_out_word      <= im2c_pkg::normalize_word(i_in.returned_word);
            end else begin
                r_source_index  <= addr.source_index;
                r_zero_fill     <= addr.zero_fill;
                r_final_element <= addr.final_element;
                r_out_word      <= '0;
            end
        end
    end

    assign o_out.valid         = r_valid;
    assign o_out.result_kind   = r_kind;
    assign o_out.source_index  = r_source_index;
    assign o_out.zero_fill     = r_zero_fill;
    assign o_out.final_element = r_final_element;
    assign o_out.out_word      = r_out_word;

endmodule

/* design/im2c_checker.sv */
module im2c_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_in_kind,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_out_kind,
    input logic [im2c_pkg::INDEX_W-1:0] i_out_index
);

    // Output register is empty after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result beat valid right after reset");

    // Every taken input beat shows up as a result beat in the next cycle
    a_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> (i_out_valid && i_out_kind == $past(i_in_kind)))
        else $error("result beat missing or of wrong kind after input beat");

    // Input side never blocks while the output register is empty
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input not ready while output register empty");

    // A stalled result beat holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_index)))
        else $error("stalled result beat changed");

endmodule

bind im2col1d_gather_address_generator_core im2c_checker u_im2c_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_kind   (i_in.kind),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_kind  (o_out.result_kind),
    .i_out_index (o_out.source_index)
);

/* tb/sv/tb_top.sv */
module tb_top;
    import im2c_pkg::*;

    // Expected result beat
    typedef struct packed {
        logic               result_kind;
        logic [INDEX_W-1:0] source_index;
        logic               zero_fill;
        logic               final_element;
        logic [WORD_W-1:0]  out_word;
    } gather_beat_t;

    logic clk;
    logic rst_n;

    im2c_in_if  in_bus();
    im2c_out_if out_bus();
    im2c_cfg_if cfg_bus();

    im2col1d_gather_address_generator_core u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cfg   (cfg_bus),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    // Walk state and geometry of the predictor
    t_cfg               geom;
    logic [CNT8_W-1:0]  tap_idx;
    logic [CHAN_W-1:0]  chan_idx;
    logic [LEN_W-1:0]   pos_idx;
    logic [CNT8_W-1:0]  batch_idx;
    longint             win_start;
    logic [OFFSET_W-1:0] tap_off;
    logic [INDEX_W-1:0] row_addr;
    logic [INDEX_W-1:0] batch_addr;

    gather_beat_t gather_results_q[$];
    int           error_count = 0;
    int           results_seen = 0;
    bit           steady_flow = 1'b0;
    bit           hold_req = 1'b0;
    int           hold_left = 0;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Abort a hung run
    initial begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

    task automatic report_mismatch(string what);
        if (error_count < 100) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
        error_count++;
    endtask

    function automatic bit idle_this_cycle();
        return !steady_flow && ($urandom_range(0, 99) < 31);
    endfunction

    // Return the walk to its first element
    function automatic void rewind_walk();
        tap_idx    = '0;
        chan_idx   = '0;
        pos_idx    = '0;
        batch_idx  = '0;
        win_start  = -longint'(geom.pad_amount);
        tap_off    = '0;
        row_addr   = '0;
        batch_addr = '0;
    endfunction

    // Compute the result of one item and advance the walk
    function automatic gather_beat_t step_gather(logic kind, logic [WORD_W-1:0] word);
        gather_beat_t r;
        longint       t;
        bit           tap_wrap, chan_wrap, pos_wrap, batch_wrap;
        r = '0;
        r.result_kind = kind;
        if (kind == KIND_WORD) begin
            if ((word & ABS_MASK) > INF_BITS) begin
                r.out_word = CANON_NAN;
            end else if (word == NEG_ZERO) begin
                r.out_word = '0;
            end else begin
                r.out_word = word;
            end
            return r;
        end

        t = win_start + longint'(tap_off);
        r.zero_fill = (t < 0) || (t >= longint'(geom.input_length));
        if (!r.zero_fill) begin
            r.source_index = row_addr + INDEX_W'(t);
        end

        tap_wrap   = int'(tap_idx) + 1 >= int'(geom.tap_count);
        chan_wrap  = int'(chan_idx) + 1 >= int'(geom.num_channels);
        pos_wrap   = int'(pos_idx) + 1 >= int'(geom.output_length);
        batch_wrap = int'(batch_idx) + 1 >= int'(geom.batch_count);
        r.final_element = tap_wrap && chan_wrap && pos_wrap && batch_wrap;

        // Advance the innermost counter that has not wrapped
        if (!tap_wrap) begin
            tap_idx = tap_idx + 8'd1;
            tap_off = tap_off + OFFSET_W'(geom.tap_spacing);
        end else if (!chan_wrap) begin
            tap_idx  = '0;
            tap_off  = '0;
            chan_idx = chan_idx + 12'd1;
            row_addr = row_addr + INDEX_W'(geom.input_length);
        end else if (!pos_wrap) begin
            tap_idx   = '0;
            tap_off   = '0;
            chan_idx  = '0;
            pos_idx   = pos_idx + 20'd1;
            win_start = win_start + longint'(geom.step_size);
            row_addr  = batch_addr;
        end else if (!batch_wrap) begin
            tap_idx    = '0;
            tap_off    = '0;
            chan_idx   = '0;
            pos_idx    = '0;
            batch_idx  = batch_idx + 8'd1;
            win_start  = -longint'(geom.pad_amount);
            row_addr   = row_addr + INDEX_W'(geom.input_length);
            batch_addr = row_addr;
        end else begin
            rewind_walk();
        end
        return r;
    endfunction

    // Offer one item, hold it until taken, then predict its result
    task automatic send_beat(logic kind, logic [WORD_W-1:0] word);
        while (idle_this_cycle()) begin
            in_bus.valid <= 1'b0;
            @(posedge clk);
        end
        in_bus.valid         <= 1'b1;
        in_bus.kind          <= kind;
        in_bus.returned_word <= word;
        @(posedge clk);
        while (!in_bus.ready) @(posedge clk);
        gather_results_q.push_back(step_gather(kind, word));
    endtask

    // Drop valid and wait until every expected beat has come back
    task automatic settle();
        in_bus.valid <= 1'b0;
        while (gather_results_q.size() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(t_cfg_index idx, logic [CFG_DATA_W-1:0] value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        @(posedge clk);
        while (!cfg_bus.ready) @(posedge clk);
        case (idx)
            CFG_INPUT_LENGTH:  geom.input_length  = value[LEN_W-1:0];
            CFG_NUM_CHANNELS:  geom.num_channels  = value[CHAN_W-1:0];
            CFG_BATCH_COUNT:   geom.batch_count   = value[CNT8_W-1:0];
            CFG_TAP_COUNT:     geom.tap_count     = value[CNT8_W-1:0];
            CFG_OUTPUT_LENGTH: geom.output_length = value[LEN_W-1:0];
            CFG_STEP_SIZE:     geom.step_size     = value[CNT8_W-1:0];
            CFG_PAD_AMOUNT:    geom.pad_amount    = value[PAD_W-1:0];
            CFG_TAP_SPACING:   geom.tap_spacing   = value[CNT8_W-1:0];
            default: ;
        endcase
    endtask

    // Fill the unused upper data bits with noise on request
    function automatic logic [CFG_DATA_W-1:0] widen(logic [CFG_DATA_W-1:0] v, int w, bit dirty);
        if (!dirty) return v;
        return v | (CFG_DATA_W'($urandom) & (20'hF_FFFF << w));
    endfunction

    task automatic program_geometry(t_cfg g, bit dirty);
        settle();
        write_reg(CFG_INPUT_LENGTH,  g.input_length);
        write_reg(CFG_NUM_CHANNELS,  widen(CFG_DATA_W'(g.num_channels), CHAN_W, dirty));
        write_reg(CFG_BATCH_COUNT,   widen(CFG_DATA_W'(g.batch_count), CNT8_W, dirty));
        write_reg(CFG_TAP_COUNT,     widen(CFG_DATA_W'(g.tap_count), CNT8_W, dirty));
        write_reg(CFG_OUTPUT_LENGTH, g.output_length);
        write_reg(CFG_STEP_SIZE,     widen(CFG_DATA_W'(g.step_size), CNT8_W, dirty));
        write_reg(CFG_PAD_AMOUNT,    widen(CFG_DATA_W'(g.pad_amount), PAD_W, dirty));
        write_reg(CFG_TAP_SPACING,   widen(CFG_DATA_W'(g.tap_spacing), CNT8_W, dirty));
        cfg_bus.valid <= 1'b0;
    endtask

    function automatic t_cfg flat_geometry(int in_len, int taps);
        t_cfg g;
        g.input_length  = LEN_W'(in_len);
        g.num_channels  = 12'd1;
        g.batch_count   = 8'd1;
        g.tap_count     = CNT8_W'(taps);
        g.output_length = 20'd1;
        g.step_size     = 8'd1;
        g.pad_amount    = '0;
        g.tap_spacing   = 8'd1;
        return g;
    endfunction

    // Mostly small counts, now and then zero or the field maximum
    function automatic int pick_count(int lo, int hi, int top);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 4) return 0;
        if (roll < 8) return top;
        return $urandom_range(lo, hi);
    endfunction

    function automatic t_cfg random_geometry();
        t_cfg g;
        g.input_length  = LEN_W'(pick_count(1, 12, 20'hF_FFFF));
        g.num_channels  = CHAN_W'(pick_count(1, 3, 12'hFFF));
        g.batch_count   = CNT8_W'(pick_count(1, 3, 8'hFF));
        g.tap_count     = CNT8_W'(pick_count(1, 4, 8'hFF));
        g.output_length = LEN_W'(pick_count(1, 5, 20'hF_FFFF));
        g.step_size     = CNT8_W'(pick_count(1, 3, 8'hFF));
        g.pad_amount    = PAD_W'(pick_count(0, 3, 10'h3FF));
        g.tap_spacing   = CNT8_W'(pick_count(1, 3, 8'hFF));
        return g;
    endfunction

    function automatic logic [WORD_W-1:0] random_word();
        case ($urandom_range(0, 5))
            0: return {1'($urandom), 8'hFF, 23'($urandom_range(1, 23'h7F_FFFF))};
            1: return NEG_ZERO;
            2: return {1'($urandom), INF_BITS[30:0]};
            3: return '0;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random_items(int count);
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 99) < 85) begin
                send_beat(KIND_ADDR, $urandom);
            end else begin
                send_beat(KIND_WORD, random_word());
            end
        end
    endtask

    // Compare one field of a result beat
    task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("beat %0d %s got %0h want %0h",
                                      results_seen, name, got, want));
        end
    endtask

    task automatic check_result();
        gather_beat_t want;
        if (gather_results_q.size() == 0) begin
            report_mismatch($sformatf("beat %0d arrived with nothing expected", results_seen));
            return;
        end
        want = gather_results_q.pop_front();
        check_field("result_kind", 64'(out_bus.result_kind), 64'(want.result_kind));
        check_field("source_index", 64'(out_bus.source_index), 64'(want.source_index));
        check_field("zero_fill", 64'(out_bus.zero_fill), 64'(want.zero_fill));
        check_field("final_element", 64'(out_bus.final_element), 64'(want.final_element));
        check_field("out_word", 64'(out_bus.out_word), 64'(want.out_word));
    endtask

    // Receive and check result beats; stall at random or for a long hold
    always @(posedge clk) begin
        if (rst_n && out_bus.valid && out_bus.ready) begin
            check_result();
            results_seen++;
        end
        if (hold_req) begin
            hold_left = 60;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_bus.ready <= 1'b0;
        end else begin
            out_bus.ready <= steady_flow || ($urandom_range(0, 99) >= 31);
        end
    end

    // Default geometry: one short row, three taps, final on the third request
    task automatic test_reset_walk();
        repeat (4) send_beat(KIND_ADDR, '0);
    endtask

    task automatic test_word_normalize();
        send_beat(KIND_WORD, 32'h7FC0_0000);
        send_beat(KIND_WORD, 32'hFFFF_FFFF);
        send_beat(KIND_WORD, 32'h7F80_0001);
        send_beat(KIND_WORD, INF_BITS);
        send_beat(KIND_WORD, 32'hFF80_0000);
        send_beat(KIND_WORD, NEG_ZERO);
        send_beat(KIND_WORD, 32'h0000_0000);
        send_beat(KIND_WORD, 32'h8000_0001);
        send_beat(KIND_WORD, 32'h3F80_0000);
    endtask

    // Largest geometry: taps climb out of the left padding into the row
    task automatic test_extreme_geometry();
        t_cfg g;
        g.input_length  = 20'hF_FFFF;
        g.num_channels  = 12'hFFF;
        g.batch_count   = 8'hFF;
        g.tap_count     = 8'hFF;
        g.output_length = 20'hF_FFFF;
        g.step_size     = 8'hFF;
        g.pad_amount    = 10'h3FF;
        g.tap_spacing   = 8'hFF;
        program_geometry(g, 1'b0);
        repeat (6) send_beat(KIND_ADDR, '0);
    endtask

    // Zero counts act as one, zero length fills every element with zeros
    task automatic test_zero_counts();
        t_cfg g;
        g = '0;
        program_geometry(g, 1'b1);
        repeat (3) send_beat(KIND_ADDR, '0);
    endtask

    // Lower the tap count while the tap counter sits past the new bound
    task automatic test_shrink_mid_walk();
        program_geometry(flat_geometry(8, 6), 1'b0);
        repeat (4) send_beat(KIND_ADDR, '0);
        program_geometry(flat_geometry(8, 2), 1'b0);
        repeat (2) send_beat(KIND_ADDR, '0);
    endtask

    // Hold the receiver so the block fills and stalls its input
    task automatic test_backpressure();
        t_cfg g;
        g = flat_geometry(5, 3);
        g.num_channels  = 12'd2;
        g.output_length = 20'd3;
        g.pad_amount    = 10'd1;
        program_geometry(g, 1'b0);
        steady_flow = 1'b1;
        hold_req    = 1'b1;
        send_random_items(40);
        steady_flow = 1'b0;
        settle();
    endtask

    task automatic test_random_geometry();
        for (int phase = 0; phase < 12; phase++) begin
            program_geometry(random_geometry(), $urandom_range(0, 3) == 0);
            steady_flow = (phase == 5);
            send_random_items(90);
            steady_flow = 1'b0;
        end
    endtask

    initial begin
        clk                  = 1'b0;
        rst_n                = 1'b0;
        in_bus.valid         = 1'b0;
        in_bus.kind          = KIND_ADDR;
        in_bus.returned_word = '0;
        cfg_bus.valid        = 1'b0;
        cfg_bus.index        = CFG_INPUT_LENGTH;
        cfg_bus.data         = '0;
        out_bus.ready        = 1'b0;

        geom = flat_geometry(1, 3);
        rewind_walk();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_walk();
        test_word_normalize();
        test_extreme_geometry();
        test_zero_counts();
        test_shrink_mid_walk();
        test_backpressure();
        test_random_geometry();

        // Drain, then allow a few cycles for stray beats
        in_bus.valid <= 1'b0;
        for (int n = 0; n < 5000 && gather_results_q.size() != 0; n++) @(posedge clk);
        repeat (8) @(posedge clk);
        if (gather_results_q.size() != 0) begin
            report_mismatch($sformatf("%0d expected beats never arrived",
                                      gather_results_q.size()));
        end
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

/* im2col1d_gather_address_generator_core.f */
design/im2c_pkg.sv
design/im2c_if.sv
design/im2c_walker.sv
design/im2col1d_gather_address_generator_core.sv
design/im2c_checker.sv
tb/sv/tb_top.sv
